/* design/q15_sine_cosine_unit_defines.svh */
// Assertion macros for the Q15 sine/cosine unit.
// No dependencies; included by the top level.
`ifndef Q15_SINE_COSINE_UNIT_DEFINES_SVH
`define Q15_SINE_COSINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define Q15SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define Q15SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/q15sc_pkg.sv */
// Shared types, constants and the Q15 high-half multiply for the sine/cosine unit.
// No dependencies.
`default_nettype none

package q15sc_pkg;

	localparam logic [15:0] QUAD_BIAS  = 16'h2000;
	localparam logic [15:0] COS_OFFSET = 16'h4000;
	localparam logic [15:0] X_MIN      = 16'h8000;
	localparam logic [15:0] X_MIN_FIX  = 16'h8001;

	// even polynomial (cosine-like arc)
	localparam logic signed [15:0] C_EVEN_0 = 16'sd2039;
	localparam logic signed [15:0] C_EVEN_1 = -16'sd20209;
	localparam logic signed [15:0] C_EVEN_2 = 16'sd32767;
	// odd polynomial (sine-like arc)
	localparam logic signed [15:0] C_ODD_0  = 16'sd322;
	localparam logic signed [15:0] C_ODD_1  = -16'sd5291;
	localparam logic signed [15:0] C_ODD_2  = 16'sd25736;

	localparam logic CMD_SIN = 1'b0;
	localparam logic CMD_COS = 1'b1;

	// quadrant bits 15:14 of (a + 0x2000)
	typedef struct packed {
		logic neg;   // bit 15: negate result
		logic even;  // bit 14: use even polynomial
	} quad_t;

	function automatic logic signed [15:0] mul_high(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [31:0] p;
		p = a * b;
		return p[31:16];
	endfunction

endpackage

`default_nettype wire

/* design/q15sc_prep.sv */
// Angle preparation: cosine offset, quadrant pick, x4 scaling with full-scale fix.
// Depends on q15sc_pkg.
`default_nettype none

module q15sc_prep (
	input  wire logic                 command,
	input  wire logic signed [15:0]   angle,
	output q15sc_pkg::quad_t          quad,
	output logic signed [15:0]        x
);

	logic [15:0] a;
	logic [15:0] biased;
	logic [15:0] shifted;

	always_comb begin
		if (command == q15sc_pkg::CMD_COS) begin
			a = q15sc_pkg::COS_OFFSET - angle;
		end else begin
			a = angle;
		end
		biased   = a + q15sc_pkg::QUAD_BIAS;
		quad.neg  = biased[15];
		quad.even = biased[14];
		shifted  = {a[13:0], 2'b00};
		if (shifted == q15sc_pkg::X_MIN) begin
			x = q15sc_pkg::X_MIN_FIX;
		end else begin
			x = shifted;
		end
	end

endmodule

`default_nettype wire

/* design/q15sc_hstep.sv */
// One Horner step: high half of a*b plus an addend, 16-bit wrap.
// Depends on q15sc_pkg.
`default_nettype none

module q15sc_hstep (
	input  wire logic signed [15:0] a,
	input  wire logic signed [15:0] b,
	input  wire logic signed [15:0] addend,
	output logic signed [15:0]      y
);

	assign y = q15sc_pkg::mul_high(a, b) + addend;

endmodule

`default_nettype wire

/* design/q15_sine_cosine_unit.sv */
// Q15 sin(pi*x)/cos(pi*x): six register stages, one word accepted per cycle while the output is not stalled.
// Pipeline: six register stages, s1 through s6; m_tvalid rises when the word reaches s6.
// Throughput: one word per clock while m_tready is high; each stage holds one word and has its own
// ready, so bubbles collapse and a stalled output does not block entry early.
// Reset: arst_n asynchronous active low clears all stage valid bits only.
// Depends on q15sc_pkg, q15sc_prep, q15sc_hstep and the defines header.
`default_nettype none
`include "q15_sine_cosine_unit_defines.svh"

module q15_sine_cosine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] angle
	input  wire logic        s_tuser,   // [0] command (0 sine, 1 cosine)
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [15:0] value
);

	// Stage map:
	//  s1  prepared x and quadrant
	//  s2  xx = 2*mulhi(x,x)
	//  s3  y = mulhi(c0,xx) + c1
	//  s4  y = mulhi(y,xx)  + c2
	//  s5  odd arc: y = 2*mulhi(y,x) + 1; even arc passes y
	//  s6  optional negate, output register

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	q15sc_pkg::quad_t quad_s1, quad_s2, quad_s3, quad_s4;
	logic             neg_s5;
	logic signed [15:0] x_s1, x_s2, x_s3, x_s4;
	logic signed [15:0] xx_s2, xx_s3;
	logic signed [15:0] y_s3, y_s4, y_s5;
	logic [15:0]        value_s6;

	// per-stage ready: a stage takes a word when empty or when it drains
	assign rdy6     = !v_s6 || m_tready;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// stage 1 logic
	q15sc_pkg::quad_t   prep_quad;
	logic signed [15:0] prep_x;

	q15sc_prep u_prep (
		.command (s_tuser),
		.angle   (s_tdata),
		.quad    (prep_quad),
		.x       (prep_x)
	);

	// stage 2 logic: square, doubled
	logic signed [15:0] sq_hi;
	assign sq_hi = q15sc_pkg::mul_high(x_s1, x_s1);

	// stage 3 and 4 Horner steps
	logic signed [15:0] h1_c0, h1_c1, h2_c2;
	logic signed [15:0] h1_y, h2_y;

	assign h1_c0 = quad_s2.even ? q15sc_pkg::C_EVEN_0 : q15sc_pkg::C_ODD_0;
	assign h1_c1 = quad_s2.even ? q15sc_pkg::C_EVEN_1 : q15sc_pkg::C_ODD_1;
	assign h2_c2 = quad_s3.even ? q15sc_pkg::C_EVEN_2 : q15sc_pkg::C_ODD_2;

	q15sc_hstep u_h1 (
		.a      (h1_c0),
		.b      (xx_s2),
		.addend (h1_c1),
		.y      (h1_y)
	);

	q15sc_hstep u_h2 (
		.a      (y_s3),
		.b      (xx_s3),
		.addend (h2_c2),
		.y      (h2_y)
	);

	// stage 5 logic: odd arc multiplies by x once more
	logic signed [15:0] odd_hi;
	logic signed [15:0] arc_y;
	assign odd_hi = q15sc_pkg::mul_high(y_s4, x_s4);
	assign arc_y  = quad_s4.even ? y_s4 : {odd_hi[14:0], 1'b1};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			quad_s1 <= prep_quad;
			x_s1    <= prep_x;
		end
		if (rdy2 && v_s1) begin
			quad_s2 <= quad_s1;
			x_s2    <= x_s1;
			xx_s2   <= {sq_hi[14:0], 1'b0};
		end
		if (rdy3 && v_s2) begin
			quad_s3 <= quad_s2;
			x_s3    <= x_s2;
			xx_s3   <= xx_s2;
			y_s3    <= h1_y;
		end
		if (rdy4 && v_s3) begin
			quad_s4 <= quad_s3;
			x_s4    <= x_s3;
			y_s4    <= h2_y;
		end
		if (rdy5 && v_s4) begin
			neg_s5 <= quad_s4.neg;
			y_s5   <= arc_y;
		end
		if (rdy6 && v_s5) begin
			value_s6 <= neg_s5 ? 16'(16'd0 - y_s5) : y_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = value_s6;

	// checks
	`Q15SC_ASSERT_NOW(a_full_when_blocked, clk, arst_n, !s_tready,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !m_tready,
		"input blocked while pipeline has a free slot")
	`Q15SC_ASSERT_NEXT(a_s5_moves_on, clk, arst_n, v_s5 && rdy6, v_s6,
		"word lost between stage 5 and output")
	`Q15SC_ASSERT_NEXT(a_out_holds, clk, arst_n, v_s6 && !m_tready,
		v_s6 && $stable(value_s6), "output register changed under stall")

endmodule

`default_nettype wire
